/* rtl/assert_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions disabled while reset is high.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/smb_pkg.sv */
//------------------------------------------------------------------------------
// Segment move buffer package
// Field widths, action and register codes, and the result record.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package smb_pkg;

   localparam int DATA_W     = 8;
   localparam int START_W    = 8;
   localparam int LENGTH_W   = 9;
   localparam int DEST_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEG_START  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_POS   = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              last;
      logic              empty_res;
   } rsp_type;

endpackage

/* rtl/smb_if.sv */
//------------------------------------------------------------------------------
// Segment move buffer channels
// Valid/ready channels for request and response transactions.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [smb_pkg::DATA_W-1:0] data_in;

   modport source (output valid, output action, output data_in, input ready);
   modport sink (input valid, input action, input data_in, output ready);
endinterface

interface smb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [smb_pkg::DATA_W-1:0] data_out;
   logic                       last;
   logic                       empty_res;

   modport source (output valid, output data_out, output last, output empty_res,
                   input ready);
   modport sink (input valid, input data_out, input last, input empty_res,
                 output ready);
endinterface

/* rtl/segment_move_buffer.sv */
//------------------------------------------------------------------------------
// Segment move buffer
// Loads bytes into a single-port buffer and reads them back with one segment
// moved before a chosen original position.
//------------------------------------------------------------------------------
// A read transaction's data and flags are registered on acceptance, then move
// into the response register once that register is free.
// Throughput: one load or read transaction per cycle while the output is not
// stalled; set by one memory access per cycle and the single response register.
// Reset: synchronous; clears the settings, count, read position, valid flags.
// The element memory is not cleared; no clearing pass is needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_move_buffer #(
   parameter int CAPACITY = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   smb_req_if.sink                            req,
   smb_rsp_if.source                          rsp,
   input  logic                               csr_wr_en,
   input  logic [smb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [smb_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import smb_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = ((CW > DEST_W) ? CW : DEST_W) + 2;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [DATA_W-1:0]          mem [CAPACITY];

   logic [START_W-1:0]         seg_start_ff;
   logic [LENGTH_W-1:0]        seg_length_ff;
   logic [DEST_W-1:0]          dest_pos_ff;
   logic [CW-1:0]              cnt_ff;
   logic [CW-1:0]              cnt_in;
   logic [CW-1:0]              idx_ff;
   logic [CW-1:0]              idx_in;
   logic                       pend_ff;
   logic                       pend_last_ff;
   logic                       pend_empty_ff;
   logic [DATA_W-1:0]          rd_data_ff;
   logic                       out_valid_ff;
   rsp_type                    out_ff;

   logic                       out_free;
   logic                       req_acc;
   logic                       rd_acc;
   logic                       ld_acc;
   logic                       is_empty;
   logic                       is_last;
   logic [CW-1:0]              idx_next;

   logic signed [IW-1:0]       n_s;
   logic signed [IW-1:0]       i_s;
   logic signed [IW-1:0]       s_s;
   logic signed [IW-1:0]       d_s;
   logic signed [IW-1:0]       len_s;
   logic signed [IW-1:0]       avail_s;
   logic signed [IW-1:0]       lenc_s;
   logic signed [IW-1:0]       src_s;
   logic                       identity;
   logic [AW-1:0]              rd_addr;

   // Control and handshake.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = !pend_ff || out_free;
   assign req_acc   = req.valid && req.ready;
   assign rd_acc    = req_acc && (req.action == ACT_READ);
   assign ld_acc    = req_acc && (req.action == ACT_LOAD);
   assign is_empty  = (cnt_ff == '0);
   assign idx_next  = idx_ff + CW'(1);
   assign is_last   = (idx_next == cnt_ff);

   // Map the output position to its original index.
   always_comb begin
      n_s     = {{(IW-CW){1'b0}}, cnt_ff};
      i_s     = {{(IW-CW){1'b0}}, idx_ff};
      s_s     = {{(IW-START_W){1'b0}}, seg_start_ff};
      d_s     = {{(IW-DEST_W){dest_pos_ff[DEST_W-1]}}, dest_pos_ff};
      len_s   = {{(IW-LENGTH_W){1'b0}}, seg_length_ff};
      avail_s = n_s - s_s;
      lenc_s  = (len_s > avail_s) ? avail_s : len_s;
      identity = (s_s >= n_s) || (d_s < 0) || (d_s == s_s) || (d_s > n_s) ||
                 (lenc_s == 0) || ((d_s > s_s) && (d_s <= s_s + lenc_s));
      src_s = i_s;
      if (!identity) begin
         if (d_s < s_s) begin
            if (i_s < d_s) begin
               src_s = i_s;
            end else if (i_s < d_s + lenc_s) begin
               src_s = s_s + i_s - d_s;
            end else if (i_s < s_s + lenc_s) begin
               src_s = i_s - lenc_s;
            end
         end else begin
            if (i_s < s_s) begin
               src_s = i_s;
            end else if (i_s < d_s - lenc_s) begin
               src_s = i_s + lenc_s;
            end else if (i_s < d_s) begin
               src_s = s_s + i_s - d_s + lenc_s;
            end
         end
      end
      rd_addr = src_s[AW-1:0];
   end

   // Count and read position.
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (ld_acc && (cnt_ff != CAP_COUNT)) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (rd_acc && !is_empty) begin
         if (is_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_next;
         end
      end
   end

   // Element memory.
   always_ff @(posedge clock) begin
      if (ld_acc && (cnt_ff != CAP_COUNT)) begin
         mem[cnt_ff[AW-1:0]] <= req.data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_acc && !is_empty) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_ff  <= '0;
         seg_length_ff <= '0;
         dest_pos_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEG_START:  seg_start_ff  <= csr_wr_data[START_W-1:0];
            CSR_SEG_LENGTH: seg_length_ff <= csr_wr_data[LENGTH_W-1:0];
            CSR_DEST_POS:   dest_pos_ff   <= csr_wr_data[DEST_W-1:0];
            default: ;
         endcase
      end
   end

   // State, pending read and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         if (rd_acc) begin
            pend_ff <= 1'b1;
         end else if (out_free) begin
            pend_ff <= 1'b0;
         end
         if (pend_ff && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_acc) begin
         pend_last_ff  <= is_last && !is_empty;
         pend_empty_ff <= is_empty;
      end
      if (pend_ff && out_free) begin
         out_ff.data_out  <= pend_empty_ff ? '0 : rd_data_ff;
         out_ff.last      <= pend_last_ff;
         out_ff.empty_res <= pend_empty_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.data_out  = out_ff.data_out;
   assign rsp.last      = out_ff.last;
   assign rsp.empty_res = out_ff.empty_res;

   `ASSERT_SAME(a_idx_in_range, clock, reset, !is_empty, idx_ff < cnt_ff)
   `ASSERT_SAME(a_idx_zero_when_empty, clock, reset, is_empty, idx_ff == '0)
   `ASSERT_SAME(a_cnt_bounded, clock, reset, 1'b1, cnt_ff <= CAP_COUNT)
   `ASSERT_NEXT(a_last_clears, clock, reset, rd_acc && !is_empty && is_last, cnt_ff == '0)
   `ASSERT_SAME(a_empty_rsp, clock, reset, rsp.valid && rsp.empty_res,
                (rsp.data_out == '0) && !rsp.last)

endmodule
